// ===== hw/rtl/iee_pkg.sv =====
// Shared types, constants and helper functions of the infix expression evaluator.
package iee_pkg;

  // Stack depths and fixed-point format
  localparam int unsigned ValueDepth = 16;
  localparam int unsigned OpDepth    = 16;
  localparam int unsigned FracBits   = 32;

  localparam int unsigned VIdxW = $clog2(ValueDepth);
  localparam int unsigned VCntW = $clog2(ValueDepth + 1);
  localparam int unsigned OIdxW = $clog2(OpDepth);
  localparam int unsigned OCntW = $clog2(OpDepth + 1);

  // Divider runs one quotient bit per cycle over a 128-bit numerator
  localparam int unsigned DivSteps = 128;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [63:0] MantMax       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SignMin       = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  MaxFracDigits = 5'd19;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_OPEN
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DIV_ZERO,
    ST_MALFORMED,
    ST_OVERFLOW
  } status_e;

  // What the operator-stack scan is doing
  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OPER,
    MODE_FINAL
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_DIV,
    S_DIV_FIN,
    S_ACT,
    S_RD_OP,
    S_CHK_OP,
    S_RD_B,
    S_RD_A,
    S_ALU,
    S_MUL,
    S_MUL_FIN,
    S_NEXT,
    S_RD_RES,
    S_EMIT
  } state_e;

  // Powers of ten for the fraction digit count
  function automatic logic [63:0] pow_ten(input logic [4:0] idx);
    logic [63:0] res;
    case (idx)
      5'd0:    res = 64'd1;
      5'd1:    res = 64'd10;
      5'd2:    res = 64'd100;
      5'd3:    res = 64'd1000;
      5'd4:    res = 64'd10000;
      5'd5:    res = 64'd100000;
      5'd6:    res = 64'd1000000;
      5'd7:    res = 64'd10000000;
      5'd8:    res = 64'd100000000;
      5'd9:    res = 64'd1000000000;
      5'd10:   res = 64'd10000000000;
      5'd11:   res = 64'd100000000000;
      5'd12:   res = 64'd1000000000000;
      5'd13:   res = 64'd10000000000000;
      5'd14:   res = 64'd100000000000000;
      5'd15:   res = 64'd1000000000000000;
      5'd16:   res = 64'd10000000000000000;
      5'd17:   res = 64'd100000000000000000;
      5'd18:   res = 64'd1000000000000000000;
      5'd19:   res = 64'd10000000000000000000;
      default: res = 64'd1;
    endcase
    return res;
  endfunction

  // Saturate a 128-bit magnitude with a sign to 64-bit two's complement
  function automatic logic [63:0] sat_signed(input logic neg, input logic [127:0] mag);
    logic [63:0] lim;
    logic [63:0] lo;
    lim = neg ? SignMin : MantMax;
    lo  = mag[63:0];
    if ((mag[127:64] != 64'd0) || (lo > lim)) begin
      lo = lim;
    end
    return neg ? (64'd0 - lo) : lo;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic prec_hi(input op_e op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

// ===== hw/rtl/iee_if.sv =====
// Valid/ready channel interfaces for expression characters and results.
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic        [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/infix_expression_evaluator_top.sv =====
// Top level of the infix expression evaluator: stacks in memories, sequencer, mul and div.
//
//  channel | dir | word                          | handshake
//  --------+-----+-------------------------------+------------
//  in_i    | in  | char_code[7:0], final_char    | valid/ready
//  out_o   | out | value[63:0] signed, status[1:0] | valid/ready
//
// A digit or point only updates the pending number, and any character after an error
// is dropped; a skipped character or '(' passes the flush step, and + - * / or ')'
// also scan the operator stack. A number that ends runs through the bit-serial 128-step
// divider, as does a / reduction; the operator and value memories each have
// one registered read port, which sets the pop sequence. Reset is asynchronous and
// clears the counts and flags at once; no clearing pass. One finished result waits
// in the output register while the next expression is accepted.
module infix_expression_evaluator_top (
  input logic         clk_i,
  input logic         rst_ni,
  iee_in_if.sink      in_i,
  iee_out_if.source   out_o
);
  import iee_pkg::*;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [VCntW-1:0]   vcnt_q, vcnt_d;
  logic [OCntW-1:0]   ocnt_q, ocnt_d;
  logic [63:0]        acc_q, acc_d;
  logic [4:0]         fd_q, fd_d;
  logic               innum_q, innum_d;
  logic               point_q, point_d;
  status_e            err_q, err_d;
  logic [7:0]         char_q, char_d;
  logic               fin_q, fin_d;
  logic               finph_q, finph_d;
  logic               flush_q, flush_d;
  op_e                curop_q, curop_d;
  op_e                redop_q, redop_d;
  logic [63:0]        a_q, a_d;
  logic [63:0]        b_q, b_d;
  logic               neg_q, neg_d;
  logic [127:0]       prod_q, prod_d;
  logic [1:0]         mcnt_q, mcnt_d;
  logic [127:0]       num_q, num_d;
  logic [127:0]       quo_q, quo_d;
  logic [63:0]        rem_q, rem_d;
  logic [63:0]        den_q, den_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic               ov_q, ov_d;
  logic [63:0]        oval_q, oval_d;
  status_e            ost_q, ost_d;

  // Memory ports
  logic [63:0]        vmem [ValueDepth];
  logic [63:0]        vrd_q;
  logic               v_we;
  logic [VIdxW-1:0]   v_waddr, v_raddr;
  logic [63:0]        v_wdata;
  op_e                omem [OpDepth];
  op_e                ord_q;
  logic               o_we;
  logic [OIdxW-1:0]   o_waddr, o_raddr;
  op_e                o_wdata;

  // Decoded character and scan decisions
  logic               in_fire;
  logic               is_digit, is_point, is_open;
  logic [3:0]         dig;
  logic [67:0]        acc_x10;
  logic               chk_reduce;
  logic [64:0]        div_r2;
  logic               div_ge;
  logic [127:0]       div_round;
  logic [63:0]        pp;
  logic [127:0]       mul_round;
  logic [63:0]        addsub;

  assign in_fire  = in_i.valid && in_i.ready;
  assign is_digit = (in_i.char_code >= CH_ZERO) && (in_i.char_code <= CH_NINE);
  assign is_point = in_i.char_code == CH_POINT;
  assign is_open  = char_q == CH_OPEN;
  assign dig      = 4'(in_i.char_code - CH_ZERO);
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, dig};

  assign chk_reduce = (ocnt_q != '0) && (ord_q != OP_OPEN) &&
                      ((mode_q != MODE_OPER) || (prec_hi(ord_q) >= prec_hi(curop_q)));

  assign div_r2    = {rem_q, num_q[127]};
  assign div_ge    = div_r2 >= {1'b0, den_q};
  assign div_round = quo_q + {127'd0, (rem_q >= (den_q - rem_q))};

  assign pp        = (mcnt_q[0] ? {32'd0, a_q[63:32]} : {32'd0, a_q[31:0]}) *
                     (mcnt_q[1] ? {32'd0, b_q[63:32]} : {32'd0, b_q[31:0]});
  assign mul_round = (prod_q + (128'd1 << (FracBits - 1))) >> FracBits;

  // Saturating add or subtract of the popped operands
  always_comb begin
    if (redop_q == OP_SUB) begin
      addsub = a_q - b_q;
      if ((a_q[63] != b_q[63]) && (addsub[63] != a_q[63])) begin
        addsub = a_q[63] ? SignMin : MantMax;
      end
    end else begin
      addsub = a_q + b_q;
      if ((a_q[63] == b_q[63]) && (addsub[63] != a_q[63])) begin
        addsub = a_q[63] ? SignMin : MantMax;
      end
    end
  end

  assign in_i.ready   = state_q == S_IDLE;
  assign out_o.valid  = ov_q;
  assign out_o.value  = oval_q;
  assign out_o.status = ost_q;

  // Stack memories, registered read
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    vrd_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (o_we) begin
      omem[o_waddr] <= o_wdata;
    end
    ord_q <= omem[o_raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((err_q != ST_OK) || is_digit || is_point) state_d = S_NEXT;
          else state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!innum_q) state_d = finph_q ? S_RD_OP : S_ACT;
        else if (vcnt_q >= VCntW'(ValueDepth)) state_d = S_NEXT;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (dcnt_q == DivCntW'(DivSteps - 1)) state_d = S_DIV_FIN;
      end
      S_DIV_FIN: begin
        if (flush_q && !finph_q) state_d = S_ACT;
        else state_d = S_RD_OP;
      end
      S_ACT: begin
        if (is_open) state_d = S_NEXT;
        else if (mode_q == MODE_CLOSE || mode_q == MODE_OPER) state_d = S_RD_OP;
        else state_d = S_NEXT;
      end
      S_RD_OP: state_d = S_CHK_OP;
      S_CHK_OP: begin
        if ((ocnt_q == '0) && (mode_q == MODE_FINAL)) begin
          state_d = (vcnt_q == VCntW'(1)) ? S_RD_RES : S_NEXT;
        end else if (chk_reduce) begin
          state_d = (vcnt_q < VCntW'(2)) ? S_NEXT : S_RD_B;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_RD_B: state_d = S_RD_A;
      S_RD_A: state_d = S_ALU;
      S_ALU: begin
        case (redop_q)
          OP_MUL:  state_d = S_MUL;
          OP_DIV:  state_d = (b_q == 64'd0) ? S_NEXT : S_DIV;
          default: state_d = S_RD_OP;
        endcase
      end
      S_MUL: begin
        if (mcnt_q == 2'd3) state_d = S_MUL_FIN;
      end
      S_MUL_FIN: state_d = S_RD_OP;
      S_NEXT: begin
        if (!fin_q) state_d = S_IDLE;
        else if ((err_q != ST_OK) || finph_q) state_d = S_EMIT;
        else state_d = S_FLUSH;
      end
      S_RD_RES: state_d = S_EMIT;
      S_EMIT: begin
        if (!ov_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mode_d  = mode_q;   vcnt_d  = vcnt_q;   ocnt_d  = ocnt_q;
    acc_d   = acc_q;    fd_d    = fd_q;     innum_d = innum_q;
    point_d = point_q;  err_d   = err_q;    char_d  = char_q;
    fin_d   = fin_q;    finph_d = finph_q;  flush_d = flush_q;
    curop_d = curop_q;  redop_d = redop_q;  a_d     = a_q;
    b_d     = b_q;      neg_d   = neg_q;    prod_d  = prod_q;
    mcnt_d  = mcnt_q;   num_d   = num_q;    quo_d   = quo_q;
    rem_d   = rem_q;    den_d   = den_q;    dcnt_d  = dcnt_q;
    oval_d  = oval_q;   ost_d   = ost_q;
    ov_d    = ov_q && !out_o.ready;
    v_we    = 1'b0;
    v_waddr = vcnt_q[VIdxW-1:0];
    v_wdata = addsub;
    v_raddr = '0;
    o_we    = 1'b0;
    o_waddr = ocnt_q[OIdxW-1:0];
    o_wdata = curop_q;
    o_raddr = OIdxW'(ocnt_q - 1'b1);

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          char_d = in_i.char_code;
          fin_d  = in_i.final_char;
          if (err_q == ST_OK) begin
            if (is_digit) begin
              // Accumulate decimal mantissa, saturate or drop digits
              innum_d = 1'b1;
              if (!point_q) begin
                acc_d = (acc_x10 > {4'd0, MantMax}) ? MantMax : acc_x10[63:0];
              end else if ((fd_q < MaxFracDigits) && (acc_x10 <= {4'd0, MantMax})) begin
                acc_d = acc_x10[63:0];
                fd_d  = fd_q + 5'd1;
              end
            end else if (is_point) begin
              if (innum_q && point_q) begin
                err_d = ST_MALFORMED;
              end else begin
                innum_d = 1'b1;
                point_d = 1'b1;
              end
            end else begin
              mode_d = (in_i.char_code == CH_CLOSE) ? MODE_CLOSE :
                       ((in_i.char_code == CH_PLUS) || (in_i.char_code == CH_MINUS) ||
                        (in_i.char_code == CH_STAR) || (in_i.char_code == CH_SLASH)) ?
                       MODE_OPER : MODE_FINAL;
              case (in_i.char_code)
                CH_PLUS:  curop_d = OP_ADD;
                CH_MINUS: curop_d = OP_SUB;
                CH_STAR:  curop_d = OP_MUL;
                CH_SLASH: curop_d = OP_DIV;
                default:  curop_d = OP_OPEN;
              endcase
            end
          end
        end
      end
      S_FLUSH: begin
        // Convert the pending number: (M << F) / 10^D
        if (innum_q) begin
          if (vcnt_q >= VCntW'(ValueDepth)) begin
            err_d = ST_OVERFLOW;
          end
          flush_d = 1'b1;
          num_d   = {64'd0, acc_q} << FracBits;
          den_d   = pow_ten(fd_q);
          neg_d   = 1'b0;
          rem_d   = 64'd0;
          quo_d   = 128'd0;
          dcnt_d  = '0;
          innum_d = 1'b0;
          point_d = 1'b0;
          acc_d   = 64'd0;
          fd_d    = 5'd0;
        end
      end
      S_DIV: begin
        // One restoring step per cycle
        rem_d  = div_ge ? 64'(div_r2 - {1'b0, den_q}) : div_r2[63:0];
        quo_d  = {quo_q[126:0], div_ge};
        num_d  = {num_q[126:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
      end
      S_DIV_FIN: begin
        v_we    = 1'b1;
        v_wdata = sat_signed(neg_q, div_round);
        vcnt_d  = vcnt_q + 1'b1;
        flush_d = 1'b0;
      end
      S_ACT: begin
        if (is_open) begin
          if (ocnt_q >= OCntW'(OpDepth)) begin
            err_d = ST_OVERFLOW;
          end else begin
            o_we    = 1'b1;
            o_wdata = OP_OPEN;
            ocnt_d  = ocnt_q + 1'b1;
          end
        end
      end
      S_CHK_OP: begin
        if (chk_reduce) begin
          // Pop operator, start reading the two operands
          ocnt_d  = ocnt_q - 1'b1;
          redop_d = ord_q;
          if (vcnt_q < VCntW'(2)) err_d = ST_MALFORMED;
          v_raddr = VIdxW'(vcnt_q - 1'b1);
        end else if ((ocnt_q == '0) && (mode_q == MODE_FINAL)) begin
          if (vcnt_q != VCntW'(1)) err_d = ST_MALFORMED;
        end else if ((ocnt_q == '0) && (mode_q == MODE_CLOSE)) begin
          err_d = ST_MALFORMED;
        end else if (mode_q == MODE_FINAL) begin
          err_d = ST_MALFORMED;
        end else if (mode_q == MODE_CLOSE) begin
          ocnt_d = ocnt_q - 1'b1;
        end else if (ocnt_q >= OCntW'(OpDepth)) begin
          err_d = ST_OVERFLOW;
        end else begin
          o_we   = 1'b1;
          ocnt_d = ocnt_q + 1'b1;
        end
      end
      S_RD_B: begin
        b_d     = vrd_q;
        v_raddr = VIdxW'(vcnt_q - VCntW'(2));
      end
      S_RD_A: begin
        a_d    = vrd_q;
        vcnt_d = vcnt_q - VCntW'(2);
      end
      S_ALU: begin
        neg_d = a_q[63] ^ b_q[63];
        case (redop_q)
          OP_MUL: begin
            a_d    = magnitude(a_q);
            b_d    = magnitude(b_q);
            prod_d = 128'd0;
            mcnt_d = 2'd0;
          end
          OP_DIV: begin
            if (b_q == 64'd0) begin
              err_d = ST_DIV_ZERO;
            end
            num_d   = {64'd0, magnitude(a_q)} << FracBits;
            den_d   = magnitude(b_q);
            rem_d   = 64'd0;
            quo_d   = 128'd0;
            dcnt_d  = '0;
            flush_d = 1'b0;
          end
          default: begin
            v_we   = 1'b1;
            vcnt_d = vcnt_q + 1'b1;
          end
        endcase
      end
      S_MUL: begin
        // Accumulate one 32x32 partial product per cycle
        case (mcnt_q)
          2'd0:    prod_d = prod_q + {64'd0, pp};
          2'd3:    prod_d = prod_q + ({64'd0, pp} << 64);
          default: prod_d = prod_q + ({64'd0, pp} << 32);
        endcase
        mcnt_d = mcnt_q + 2'd1;
      end
      S_MUL_FIN: begin
        v_we    = 1'b1;
        v_wdata = sat_signed(neg_q, mul_round);
        vcnt_d  = vcnt_q + 1'b1;
      end
      S_NEXT: begin
        if (fin_q && (err_q == ST_OK) && !finph_q) begin
          finph_d = 1'b1;
          mode_d  = MODE_FINAL;
        end
      end
      S_EMIT: begin
        // Load the result word and drop back to an empty expression
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          oval_d  = (err_q == ST_OK) ? vrd_q : 64'd0;
          ost_d   = err_q;
          vcnt_d  = '0;
          ocnt_d  = '0;
          acc_d   = 64'd0;
          fd_d    = 5'd0;
          innum_d = 1'b0;
          point_d = 1'b0;
          err_d   = ST_OK;
          finph_d = 1'b0;
          flush_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_OPER;
      vcnt_q  <= '0;
      ocnt_q  <= '0;
      acc_q   <= 64'd0;
      fd_q    <= 5'd0;
      innum_q <= 1'b0;
      point_q <= 1'b0;
      err_q   <= ST_OK;
      fin_q   <= 1'b0;
      finph_q <= 1'b0;
      flush_q <= 1'b0;
      mcnt_q  <= 2'd0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      vcnt_q  <= vcnt_d;
      ocnt_q  <= ocnt_d;
      acc_q   <= acc_d;
      fd_q    <= fd_d;
      innum_q <= innum_d;
      point_q <= point_d;
      err_q   <= err_d;
      fin_q   <= fin_d;
      finph_q <= finph_d;
      flush_q <= flush_d;
      mcnt_q  <= mcnt_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    curop_q <= curop_d;
    redop_q <= redop_d;
    a_q     <= a_d;
    b_q     <= b_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    oval_q  <= oval_d;
    ost_q   <= ost_d;
  end

`ifndef SYNTHESIS
  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcnt_q <= VCntW'(ValueDepth)) && (ocnt_q <= OCntW'(OpDepth)))
    else $error("stack count beyond depth");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ST_OK) && (state_q != S_EMIT)) |=> (err_q == $past(err_q)))
    else $error("first error overwritten");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ((vcnt_q == '0) && (ocnt_q == '0) && (err_q == ST_OK)))
    else $error("state not cleared after result");
`endif

endmodule
